/* rtl/power_squelch_noise_floor_macros.svh */
// Assertion helpers for the power squelch block.
`ifndef POWER_SQUELCH_NOISE_FLOOR_MACROS_SVH
`define POWER_SQUELCH_NOISE_FLOOR_MACROS_SVH

// same-cycle implication
`define PSNF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PSNF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/psnf_pkg.sv */
package psnf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int SQ_W = 2 * SAMPLE_W - 1;
	localparam int LEVEL_W = 17;
	localparam int ENERGY_W = 43;
	localparam int COUNT_W = 13;
	localparam int FLOOR_W = 25;
	localparam int MANT_W = 31;
	localparam int LOG_STEPS = 16;
	localparam int PIDX_W = 6;
	localparam int LOG_W = PIDX_W + LOG_STEPS;
	localparam int DIFF_W = LOG_W + 2;
	localparam int DB_W = 26;
	localparam int SCALE_W = DIFF_W + DB_W;
	localparam int LMAG_W = SCALE_W - 32;
	localparam int WIDE_W = FLOOR_W + 1;
	localparam int RECIP_W = 26;
	localparam int QUO_W = WIDE_W + RECIP_W - 32;

	localparam logic [COUNT_W-1:0] MAX_BLOCK = COUNT_W'(4096);
	localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
	localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -LEVEL_W'(46080);
	localparam logic [LMAG_W-1:0] LEVEL_MAG_MAX = LMAG_W'(46080);
	localparam logic [DB_W-1:0] DB_PER_LOG2 = DB_W'(50504453);
	localparam logic signed [DIFF_W-1:0] LOG_OFFSET = DIFF_W'(2 * (SAMPLE_W - 1) * 65536);
	localparam logic signed [FLOOR_W-1:0] FLOOR_RESET = -FLOOR_W'(6553600);
	localparam logic signed [LEVEL_W-1:0] THRESH_RESET = -LEVEL_W'(10240);
	localparam logic [RECIP_W-1:0] DIV100_RECIP = RECIP_W'(42949673);
	localparam logic [WIDE_W-1:0] DIV100_HALF = WIDE_W'(50);
	localparam logic signed [WIDE_W-1:0] DB3_Q16 = WIDE_W'(3 * 65536);
	localparam logic signed [WIDE_W-1:0] DB6_Q16 = WIDE_W'(6 * 65536);

	typedef struct packed {
		logic valid;
		logic [ENERGY_W-1:0] energy;
		logic [COUNT_W-1:0] count;
	} blk_t;

	typedef struct packed {
		logic valid;
		logic signed [LEVEL_W-1:0] level;
	} lvl_t;

endpackage

/* rtl/psnf_if.sv */
interface psnf_in_if;
	import psnf_pkg::*;

	logic valid;
	logic ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic last_of_block;

	modport source (output valid, sample, last_of_block, input ready);
	modport sink (input valid, sample, last_of_block, output ready);
endinterface

interface psnf_out_if;
	import psnf_pkg::*;

	logic valid;
	logic ready;
	logic signed [LEVEL_W-1:0] rms_level;
	logic signed [LEVEL_W-1:0] noise_floor;
	logic squelch_open;

	modport source (output valid, rms_level, noise_floor, squelch_open, input ready);
	modport sink (input valid, rms_level, noise_floor, squelch_open, output ready);
endinterface

/* rtl/psnf_accum.sv */
module psnf_accum (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic in_valid,
	input  logic signed [psnf_pkg::SAMPLE_W-1:0] in_sample,
	input  logic in_last,
	output psnf_pkg::blk_t blk
);
	import psnf_pkg::*;

	logic valid_s1, last_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic valid_s2, last_s2;
	logic [SQ_W-1:0] sq_s2;
	logic signed [2*SAMPLE_W-1:0] prod;
	logic [ENERGY_W-1:0] energy_q, energy_nxt;
	logic [COUNT_W-1:0] count_q, count_nxt;
	logic [ENERGY_W:0] sum;
	logic blk_valid_s3;
	logic [ENERGY_W-1:0] blk_energy_s3;
	logic [COUNT_W-1:0] blk_count_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign prod = (2*SAMPLE_W)'(sample_s1) * (2*SAMPLE_W)'(sample_s1);

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_s1 <= in_sample;
			last_s1 <= in_last;
			sq_s2 <= prod[SQ_W-1:0];
			last_s2 <= last_s1;
		end
	end

	assign sum = {1'b0, energy_q} + (ENERGY_W+1)'(sq_s2);

	always_comb begin
		if (count_q >= MAX_BLOCK) begin
			energy_nxt = ENERGY_MAX;
			count_nxt = MAX_BLOCK;
		end else begin
			energy_nxt = sum[ENERGY_W] ? ENERGY_MAX : sum[ENERGY_W-1:0];
			count_nxt = count_q + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
			count_q <= '0;
			blk_valid_s3 <= 1'b0;
		end else if (advance) begin
			blk_valid_s3 <= valid_s2 && last_s2;
			if (valid_s2) begin
				if (last_s2) begin
					energy_q <= '0;
					count_q <= '0;
				end else begin
					energy_q <= energy_nxt;
					count_q <= count_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			blk_energy_s3 <= energy_nxt;
			blk_count_s3 <= count_nxt;
		end
	end

	assign blk = '{valid: blk_valid_s3, energy: blk_energy_s3, count: blk_count_s3};
endmodule

/* rtl/psnf_log2.sv */
module psnf_log2 (
	input  logic clk,
	input  logic advance,
	input  logic [psnf_pkg::ENERGY_W-1:0] x,
	output logic [psnf_pkg::LOG_W-1:0] y
);
	import psnf_pkg::*;

	logic [PIDX_W-1:0] lead;
	logic [PIDX_W-1:0] shamt;
	logic [ENERGY_W-1:0] norm;

	logic [MANT_W-1:0] m_s [LOG_STEPS+1];
	logic [PIDX_W-1:0] p_s [LOG_STEPS+1];
	logic [LOG_STEPS-1:0] f_s [LOG_STEPS+1];

	always_comb begin
		lead = '0;
		for (int i = 0; i < ENERGY_W; i++) begin
			if (x[i]) begin
				lead = PIDX_W'(i);
			end
		end
	end

	assign shamt = PIDX_W'(ENERGY_W - 1) - lead;
	assign norm = x << shamt;

	always_ff @(posedge clk) begin
		if (advance) begin
			m_s[0] <= norm[ENERGY_W-1 -: MANT_W];
			p_s[0] <= lead;
			f_s[0] <= '0;
		end
	end

	// one fraction bit per stage: square, renormalize
	for (genvar k = 0; k < LOG_STEPS; k++) begin : g_step
		logic [2*MANT_W-1:0] sqr;
		logic [MANT_W:0] t;

		assign sqr = {{MANT_W{1'b0}}, m_s[k]} * {{MANT_W{1'b0}}, m_s[k]};
		assign t = sqr[2*MANT_W-1:MANT_W-1];

		always_ff @(posedge clk) begin
			if (advance) begin
				m_s[k+1] <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
				p_s[k+1] <= p_s[k];
				f_s[k+1] <= f_s[k] | ({{(LOG_STEPS-1){1'b0}}, t[MANT_W]} << (LOG_STEPS-1-k));
			end
		end
	end

	assign y = {p_s[LOG_STEPS], f_s[LOG_STEPS]};
endmodule

/* rtl/psnf_level.sv */
module psnf_level (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  psnf_pkg::blk_t blk,
	output psnf_pkg::lvl_t lvl
);
	import psnf_pkg::*;

	logic [LOG_W-1:0] log_sum, log_cnt;
	logic vld_s [LOG_STEPS+1];
	logic zero_s [LOG_STEPS+1];
	logic dvld_s, dzero_s;
	logic signed [DIFF_W-1:0] diff_s;
	logic [DIFF_W-1:0] mag;
	logic [SCALE_W-1:0] scaled;
	logic [LMAG_W-1:0] lmag;
	logic signed [LEVEL_W-1:0] level_nxt;
	logic lvl_valid_s;
	logic signed [LEVEL_W-1:0] lvl_level_s;

	psnf_log2 u_log_sum (
		.clk(clk),
		.advance(advance),
		.x(blk.energy),
		.y(log_sum)
	);

	psnf_log2 u_log_cnt (
		.clk(clk),
		.advance(advance),
		.x(ENERGY_W'(blk.count)),
		.y(log_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LOG_STEPS; i++) begin
				vld_s[i] <= 1'b0;
			end
			dvld_s <= 1'b0;
			lvl_valid_s <= 1'b0;
		end else if (advance) begin
			vld_s[0] <= blk.valid;
			for (int i = 0; i < LOG_STEPS; i++) begin
				vld_s[i+1] <= vld_s[i];
			end
			dvld_s <= vld_s[LOG_STEPS];
			lvl_valid_s <= dvld_s;
		end
	end

	assign mag = -diff_s;
	assign scaled = SCALE_W'(mag) * SCALE_W'(DB_PER_LOG2) + (SCALE_W'(1) << 31);
	assign lmag = scaled[SCALE_W-1:32];

	always_comb begin
		if (dzero_s) begin
			level_nxt = LEVEL_MIN;
		end else if (!diff_s[DIFF_W-1]) begin
			level_nxt = '0;
		end else if (lmag > LEVEL_MAG_MAX) begin
			level_nxt = LEVEL_MIN;
		end else begin
			level_nxt = -$signed(lmag[LEVEL_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			zero_s[0] <= (blk.energy == '0);
			for (int i = 0; i < LOG_STEPS; i++) begin
				zero_s[i+1] <= zero_s[i];
			end
			dzero_s <= zero_s[LOG_STEPS];
			diff_s <= $signed({2'b00, log_sum}) - $signed({2'b00, log_cnt}) - LOG_OFFSET;
			lvl_level_s <= level_nxt;
		end
	end

	assign lvl = '{valid: lvl_valid_s, level: lvl_level_s};
endmodule

/* rtl/psnf_floor.sv */
module psnf_floor (
	input  logic clk,
	input  logic arst_n,
	input  psnf_pkg::lvl_t lvl,
	input  logic signed [psnf_pkg::LEVEL_W-1:0] thr,
	input  logic out_ready,
	output logic advance,
	output logic out_valid,
	output logic signed [psnf_pkg::LEVEL_W-1:0] rms_level,
	output logic signed [psnf_pkg::LEVEL_W-1:0] noise_floor,
	output logic squelch_open
);
	import psnf_pkg::*;

	logic signed [FLOOR_W-1:0] floor_q, floor_nxt, step;
	logic signed [WIDE_W-1:0] lq16, d;
	logic [WIDE_W-1:0] mag, num;
	logic [WIDE_W+RECIP_W-1:0] prod;
	logic [QUO_W-1:0] quo;
	logic track;

	logic fin_valid_s;
	logic signed [LEVEL_W-1:0] fin_level_s;
	logic signed [FLOOR_W-1:0] fin_floor_s;
	logic signed [WIDE_W-1:0] fin_lq16, fin_gate;
	logic open_nxt;

	logic out_valid_q, open_q;
	logic signed [LEVEL_W-1:0] level_q, nf_q;

	assign advance = !(fin_valid_s && out_valid_q && !out_ready);

	// level in Q8.16 against floor, step = gap / 100 rounded half away from zero
	assign lq16 = WIDE_W'($signed({lvl.level, 8'b0}));
	assign track = lq16 < (WIDE_W'(floor_q) + DB3_Q16);
	assign d = lq16 - WIDE_W'(floor_q);
	assign mag = d[WIDE_W-1] ? -d : d;
	assign num = mag + DIV100_HALF;
	assign prod = (WIDE_W+RECIP_W)'(num) * (WIDE_W+RECIP_W)'(DIV100_RECIP);
	assign quo = prod[WIDE_W+RECIP_W-1:32];
	assign step = d[WIDE_W-1] ? -FLOOR_W'(quo) : FLOOR_W'(quo);
	assign floor_nxt = track ? floor_q + step : floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= FLOOR_RESET;
			fin_valid_s <= 1'b0;
		end else if (advance) begin
			fin_valid_s <= lvl.valid;
			if (lvl.valid) begin
				floor_q <= floor_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fin_level_s <= lvl.level;
			fin_floor_s <= floor_nxt;
		end
	end

	assign fin_lq16 = WIDE_W'($signed({fin_level_s, 8'b0}));
	assign fin_gate = WIDE_W'(fin_floor_s) + DB6_Q16;
	assign open_nxt = (fin_lq16 > fin_gate) || (fin_level_s > thr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && fin_valid_s) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fin_valid_s) begin
			level_q <= fin_level_s;
			nf_q <= fin_floor_s[FLOOR_W-1:8];
			open_q <= open_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign rms_level = level_q;
	assign noise_floor = nf_q;
	assign squelch_open = open_q;
endmodule

/* rtl/power_squelch_noise_floor.sv */
// Power squelch with noise floor tracking.
// in_ch carries signed Q1.15 samples with a last_of_block flag. Samples are
// squared and summed per block; the flagged sample closes the block and
// produces one item on out_ch: block RMS level and updated noise floor in
// 1/256 dB, plus the squelch decision. Unflagged samples produce nothing.
// cfg_we/cfg_data write the squelch threshold (1/256 dB, signed); write only
// while the block is idle.
// Throughput: one sample per clock while in_ch.ready is high. The result
// passes through registered steps in order: square, accumulate, normalize,
// 16 log2 squaring stages for sum and count in parallel, log difference,
// scale, floor update, output register.
// Reset clears the accumulators, sets the floor to -100 dB and the threshold
// to -40 dB, and empties the pipeline.
// A stalled receiver holds the output item; the pipeline keeps taking samples
// until a second result is waiting behind it, then in_ch.ready drops and the
// whole pipeline holds.
`include "power_squelch_noise_floor_macros.svh"

module power_squelch_noise_floor (
	input  logic clk,
	input  logic arst_n,
	psnf_in_if.sink in_ch,
	psnf_out_if.source out_ch,
	input  logic cfg_we,
	input  logic signed [psnf_pkg::LEVEL_W-1:0] cfg_data
);
	import psnf_pkg::*;

	logic advance;
	logic signed [LEVEL_W-1:0] thr_q;
	blk_t blk;
	lvl_t lvl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	assign in_ch.ready = advance;

	psnf_accum u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.in_valid(in_ch.valid),
		.in_sample(in_ch.sample),
		.in_last(in_ch.last_of_block),
		.blk(blk)
	);

	psnf_level u_level (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.blk(blk),
		.lvl(lvl)
	);

	psnf_floor u_floor (
		.clk(clk),
		.arst_n(arst_n),
		.lvl(lvl),
		.thr(thr_q),
		.out_ready(out_ch.ready),
		.advance(advance),
		.out_valid(out_ch.valid),
		.rms_level(out_ch.rms_level),
		.noise_floor(out_ch.noise_floor),
		.squelch_open(out_ch.squelch_open)
	);

	`PSNF_ASSERT_NOW(a_in_stall, !in_ch.ready, out_ch.valid && !out_ch.ready, "input stalled without output backpressure")
	`PSNF_ASSERT_NOW(a_level_range, out_ch.valid, out_ch.rms_level >= LEVEL_MIN && out_ch.rms_level <= 0, "rms level out of range")
	`PSNF_ASSERT_NOW(a_floor_range, out_ch.valid, out_ch.noise_floor >= LEVEL_MIN && out_ch.noise_floor <= 0, "noise floor out of range")
	`PSNF_ASSERT_NOW(a_thr_open, out_ch.valid && out_ch.rms_level > thr_q, out_ch.squelch_open, "level above threshold but squelch closed")
	`PSNF_ASSERT_NEXT(a_cfg_write, cfg_we, thr_q == $past(cfg_data), "threshold write lost")

endmodule

/* dv/power_squelch_noise_floor_test.sv */
`timescale 1ns / 1ps

module power_squelch_noise_floor_test;
	import psnf_pkg::*;

	localparam int RUN_LIMIT = 1_500_000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS = 100;
	localparam int MAX_PRINTS = 100;
	localparam int DB_Q16 = 65536;
	localparam longint unsigned ENERGY_TOP = (64'd1 << ENERGY_W) - 64'd1;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_FULL} block_fill_t;

	typedef struct {
		logic signed [LEVEL_W-1:0] level;
		logic signed [LEVEL_W-1:0] floor_db;
		logic open;
	} block_result_t;

	class squelch_tracker;
		longint unsigned energy;
		int count;
		longint floor_q;
		longint threshold;
		int errors;
		block_result_t results_due[$];

		function new();
			energy = 0;
			count = 0;
			floor_q = FLOOR_RESET;
			threshold = THRESH_RESET;
			errors = 0;
		endfunction

		// log2 in Q16 by repeated squaring of a Q1.30 mantissa
		function longint log2_fixed(longint unsigned x);
			int p;
			longint unsigned m;
			longint frac;
			p = 0;
			while (p < 63 && (x >> (p + 1)) != 0)
				p++;
			if (p > 30)
				m = x >> (p - 30);
			else
				m = x << (30 - p);
			frac = 0;
			for (int i = 15; i >= 0; i--) begin
				m = (m * m) >> 30;
				if (m >= 64'h8000_0000) begin
					m = m >> 1;
					frac = frac | (64'sd1 << i);
				end
			end
			return longint'(p) * DB_Q16 + frac;
		endfunction

		function longint div100_nearest(longint d);
			longint unsigned mag;
			longint q;
			mag = (d < 0) ? -d : d;
			q = longint'((mag + 64'd50) / 64'd100);
			return (d < 0) ? -q : q;
		endfunction

		function void take_sample(logic signed [SAMPLE_W-1:0] s, logic last);
			longint sv;
			longint unsigned sq;
			longint unsigned mag;
			longint lvl;
			longint diff;
			longint lq;
			longint nf;
			block_result_t r;
			sv = s;
			sq = sv * sv;
			if (count >= int'(MAX_BLOCK)) begin
				energy = ENERGY_TOP;
				count = int'(MAX_BLOCK);
			end else begin
				energy = (ENERGY_TOP - energy < sq) ? ENERGY_TOP : energy + sq;
				count++;
			end
			if (!last)
				return;
			if (energy == 0) begin
				lvl = LEVEL_MIN;
			end else begin
				diff = log2_fixed(energy) - log2_fixed(count) - 2 * (SAMPLE_W - 1) * DB_Q16;
				if (diff >= 0) begin
					lvl = 0;
				end else begin
					mag = -diff;
					lvl = -longint'((mag * 64'd50504453 + (64'd1 << 31)) >> 32);
					if (lvl < LEVEL_MIN)
						lvl = LEVEL_MIN;
				end
			end
			lq = lvl * 256;
			if (lq < floor_q + 3 * DB_Q16)
				floor_q = floor_q + div100_nearest(lq - floor_q);
			nf = floor_q >>> 8;
			r.level = lvl[LEVEL_W-1:0];
			r.floor_db = nf[LEVEL_W-1:0];
			r.open = (lq > floor_q + 6 * DB_Q16) || (lvl > threshold);
			results_due.push_back(r);
			energy = 0;
			count = 0;
		endfunction

		task report(string msg);
			if (errors < MAX_PRINTS)
				$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_block_result(logic signed [LEVEL_W-1:0] level,
				logic signed [LEVEL_W-1:0] floor_db, logic open);
			block_result_t want;
			if (results_due.size() == 0) begin
				report($sformatf("result with no block pending, level %0d", level));
				return;
			end
			want = results_due.pop_front();
			if (level !== want.level)
				report($sformatf("rms_level %0d, want %0d", level, want.level));
			if (floor_db !== want.floor_db)
				report($sformatf("noise_floor %0d, want %0d", floor_db, want.floor_db));
			if (open !== want.open)
				report($sformatf("squelch_open %0b, want %0b (level %0d)", open, want.open,
					want.level));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic signed [LEVEL_W-1:0] cfg_data;
	int cyc = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;
	squelch_tracker tracker;

	psnf_in_if in_ch();
	psnf_out_if out_ch();

	power_squelch_noise_floor u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == RUN_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: checks results and stalls in phases chosen by the cycle count, one of them random
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			tracker.check_block_result(out_ch.rms_level, out_ch.noise_floor,
				out_ch.squelch_open);
		case (cyc[10:9])
		2'd0: out_ch.ready <= 1'b1;
		2'd1: out_ch.ready <= 1'($urandom_range(0, 1));
		2'd2: out_ch.ready <= (cyc % 5) != 0;
		default: out_ch.ready <= cyc[5:0] >= 6'd24;
		endcase
	end

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = 0;
			if (gaps_on)
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= s;
		in_ch.last_of_block <= last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		tracker.take_sample(s, last);
		burst_left--;
	endtask

	task automatic send_block(input int len, input block_fill_t fill);
		logic signed [SAMPLE_W-1:0] s;
		int shift;
		shift = $urandom_range(0, SAMPLE_W - 1);
		for (int i = 0; i < len; i++) begin
			case (fill)
			FILL_ZERO: s = '0;
			FILL_FULL: s = {1'b1, {(SAMPLE_W-1){1'b0}}};
			default: begin
				s = $urandom;
				s = s >>> shift;
			end
			endcase
			send_sample(s, i == len - 1);
		end
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (tracker.results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic signed [LEVEL_W-1:0] t);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= t;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.threshold = t;
	endtask

	initial begin
		logic signed [LEVEL_W-1:0] thr_list[6];
		int n;
		int len;
		int pick;
		block_fill_t fill;
		tracker = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.sample = '0;
		in_ch.last_of_block = 1'b0;
		out_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed blocks at the reset threshold
		send_sample(16'sh0000, 1'b1);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh0001, 1'b1);
		send_sample(16'shFFFF, 1'b0);
		send_sample(16'sh5555, 1'b0);
		send_sample(16'shAAAA, 1'b0);
		send_sample(16'sh0000, 1'b1);
		send_block(3, FILL_FULL);
		send_block(4, FILL_ZERO);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh000C, 1'b1);
		send_sample(16'shFFFF, 1'b1);

		thr_list[0] = -17'sd46080;
		thr_list[1] = 17'sd0;
		thr_list[2] = 17'sh0FFFF;
		thr_list[3] = 17'sh10000;
		thr_list[4] = -LEVEL_W'($urandom_range(0, 46080));
		thr_list[5] = -LEVEL_W'($urandom_range(0, 46080));

		for (int p = 0; p < 6; p++) begin
			write_threshold(thr_list[p]);
			gaps_on = (p != 1);
			n = 0;
			while (n < PHASE_ITEMS) begin
				len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 64);
				pick = $urandom_range(0, 19);
				if (pick == 0)
					fill = FILL_ZERO;
				else if (pick == 1)
					fill = FILL_FULL;
				else
					fill = FILL_RANDOM;
				send_block(len, fill);
				n = n + len;
			end
		end

		wait_idle();
		if (tracker.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
